[rtl/triangle_circum_and_in_radius_unit_defines.svh]
// Assertion macros for the triangle radius unit.
// Used by the top level only; no other dependencies.
`ifndef TRIANGLE_CIRCUM_AND_IN_RADIUS_UNIT_DEFINES_SVH
`define TRIANGLE_CIRCUM_AND_IN_RADIUS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tcir: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TCIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tcir: next-cycle check failed");

`endif

[rtl/tcir_pkg.sv]
// Shared widths and helpers for the triangle radius unit.
// No dependencies.
package tcir_pkg;

  localparam int COORD_W         = 32;  // input coordinate width
  localparam int DIFF_W          = 33;  // coordinate difference, signed
  localparam int MAG_W           = 32;  // magnitude of a difference
  localparam int XPROD_W         = 66;  // signed cross term product
  localparam int CROSS_W         = 66;  // cross product component magnitude
  localparam int EDGE_SQ_W       = 66;  // squared edge length
  localparam int Q_W             = 132; // squared cross product length
  localparam int LEN_EXTRA       = 16;  // extra fraction bits of lengths
  localparam int OUT_FRAC        = 16;  // output fraction bits
  localparam int OUT_W           = 48;  // result width
  localparam int EDGE_IN_W       = EDGE_SQ_W + 2 * LEN_EXTRA; // 98
  localparam int LEN_W           = EDGE_IN_W / 2;             // 49
  localparam int RQ_IN_W         = Q_W + 2 * LEN_EXTRA + 2;   // 166, even
  localparam int RQ_W            = RQ_IN_W / 2;               // 83
  localparam int AB_W            = 2 * LEN_W;                 // 98
  localparam int PROD_W          = 3 * LEN_W;                 // 147
  localparam int SUM_W           = LEN_W + 2;                 // 51
  localparam int COORD_FRAC_DEF  = 16;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/tcir_sqrt.sv]
// Pipelined integer square root, one result bit per register stage, several lanes.
// Uses no package; sideband travels along with the data.
module tcir_sqrt #(
  parameter int IW    = 98,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][IW-1:0]     x_i,
  input  logic [SW-1:0]                side_i,
  output logic                         valid_o,
  output logic [LANES-1:0][IW/2-1:0]   root_o,
  output logic [SW-1:0]                side_o
);

  localparam int OW = IW / 2;
  localparam int RW = OW + 2;

  logic [OW-1:0] vld_q;

  logic [LANES-1:0][IW-1:0] x_s    [OW];
  logic [LANES-1:0][OW-1:0] root_s [OW];
  logic [LANES-1:0][RW-1:0] rem_s  [OW];
  logic [SW-1:0]            side_s [OW];

  logic [LANES-1:0][IW-1:0] x_q    [OW];
  logic [LANES-1:0][OW-1:0] root_q [OW];
  logic [LANES-1:0][RW-1:0] rem_q  [OW];
  logic [SW-1:0]            side_q [OW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[OW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < OW; k++) begin : g_stage
    localparam int HI = IW - 1 - 2 * k;

    if (k == 0) begin : g_first
      assign x_s[k]    = x_i;
      assign root_s[k] = '0;
      assign rem_s[k]  = '0;
      assign side_s[k] = side_i;
    end else begin : g_next
      assign x_s[k]    = x_q[k-1];
      assign root_s[k] = root_q[k-1];
      assign rem_s[k]  = rem_q[k-1];
      assign side_s[k] = side_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW+1:0] r2;
      logic [RW+1:0] trial;
      logic          ge;
      logic [RW+1:0] diff;

      assign r2    = {rem_s[k][l], x_s[k][l][HI -: 2]};
      assign trial = {{(RW - OW){1'b0}}, root_s[k][l], 2'b01};
      assign ge    = (r2 >= trial);
      assign diff  = ge ? (r2 - trial) : r2;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k][l]    <= x_s[k][l];
          root_q[k][l] <= {root_s[k][l][OW-2:0], ge};
          rem_q[k][l]  <= diff[RW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_s[k];
      end
    end
  end

  assign valid_o = vld_q[OW-1];
  assign root_o  = root_q[OW-1];
  assign side_o  = side_q[OW-1];

endmodule

[rtl/tcir_div.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on tcir_pkg for the default quotient width and the max_int helper.
module tcir_div #(
  parameter int NW    = 122,
  parameter int DW    = 83,
  parameter int QW    = tcir_pkg::OUT_W,
  parameter int LANES = 2,
  parameter int SW    = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [LANES-1:0][NW-1:0] num_i,
  input  logic [LANES-1:0][DW-1:0] den_i,
  input  logic [SW-1:0]            side_i,
  output logic                     valid_o,
  output logic [LANES-1:0][QW-1:0] quot_o,
  output logic [SW-1:0]            side_o
);

  localparam int CW = tcir_pkg::max_int(NW, DW + QW) + 1;

  logic [QW:0] vld_q;

  logic [LANES-1:0][CW-1:0] rem_q  [QW+1];
  logic [LANES-1:0][DW-1:0] den_q  [QW+1];
  logic [LANES-1:0][QW-1:0] quot_q [QW+1];
  logic [LANES-1:0]         ovf_q  [QW+1];
  logic [SW-1:0]            side_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  // Stage 0: flag quotients that do not fit, load the remainder.
  for (genvar l = 0; l < LANES; l++) begin : g_lane0
    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_top;

    assign num_ext = CW'(num_i[l]);
    assign den_top = CW'(den_i[l]) << QW;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l]  <= num_ext;
        den_q[0][l]  <= den_i[l];
        quot_q[0][l] <= '0;
        ovf_q[0][l]  <= (num_ext >= den_top);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int SH = QW - k;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CW-1:0] dsh;
      logic          ge;

      assign dsh = CW'(den_q[k-1][l]) << SH;
      assign ge  = (rem_q[k-1][l] >= dsh);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l]  <= ge ? (rem_q[k-1][l] - dsh) : rem_q[k-1][l];
          den_q[k][l]  <= den_q[k-1][l];
          quot_q[k][l] <= {quot_q[k-1][l][QW-2:0], ge};
          ovf_q[k][l]  <= ovf_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot_o[l] = ovf_q[QW][l] ? {QW{1'b1}} : quot_q[QW][l];
  end

  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];

endmodule

[rtl/triangle_circum_and_in_radius_unit.sv]
// Triangle circumradius and inradius from three 3-D vertices, fully pipelined.
// Depends on tcir_pkg, tcir_sqrt, tcir_div and the assertion macro header.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+--------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | ax..cz, signed fixed point coords
//   out     | output    | out_valid_o/out_ready_i| circum_radius, in_radius, degenerate
//
// One word enters and one leaves per cycle unless the output stalls. The
// bit-serial stages are 49 for the edge square roots, 83 for the root of the
// squared cross product and 49 for the two divisions, plus 10 arithmetic stages.
// Reset clears only the valid bits; data registers carry no reset.
// A stall at the output freezes the whole pipeline in place, so nothing is lost
// or repeated, and in_ready_o follows the output register being free.
`include "triangle_circum_and_in_radius_unit_defines.svh"

module triangle_circum_and_in_radius_unit #(
  parameter int COORD_FRAC_BITS = tcir_pkg::COORD_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [tcir_pkg::COORD_W-1:0] ax_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] ay_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] az_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] bx_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] by_coord_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] bz_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] cx_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] cy_i,
  input  logic signed [tcir_pkg::COORD_W-1:0] cz_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tcir_pkg::OUT_W-1:0]         circum_radius_o,
  output logic [tcir_pkg::OUT_W-1:0]         in_radius_o,
  output logic                               degenerate_o
);

  localparam int CW    = tcir_pkg::COORD_W;
  localparam int DFW   = tcir_pkg::DIFF_W;
  localparam int MW    = tcir_pkg::MAG_W;
  localparam int XW    = tcir_pkg::XPROD_W;
  localparam int NW    = tcir_pkg::CROSS_W;
  localparam int EW    = tcir_pkg::EDGE_SQ_W;
  localparam int QW    = tcir_pkg::Q_W;
  localparam int LW    = tcir_pkg::LEN_W;
  localparam int RW    = tcir_pkg::RQ_W;
  localparam int ABW   = tcir_pkg::AB_W;
  localparam int PW    = tcir_pkg::PROD_W;
  localparam int SMW   = tcir_pkg::SUM_W;
  localparam int OW    = tcir_pkg::OUT_W;
  localparam int XTRA  = tcir_pkg::LEN_EXTRA;
  localparam int OFRAC = tcir_pkg::OUT_FRAC;

  // circumradius = floor((la*lb*lc >> CN_SHIFT) / rq)
  localparam int CN_SHIFT = COORD_FRAC_BITS + 1 + 2 * XTRA - OFRAC;
  localparam int CN_W     = PW - CN_SHIFT;
  localparam int IN_NUM_W = RW + OFRAC;
  localparam int IN_DEN_W = SMW + COORD_FRAC_BITS;
  localparam int DNW      = tcir_pkg::max_int(CN_W, IN_NUM_W);
  localparam int DDW      = tcir_pkg::max_int(RW, IN_DEN_W);

  // Whole pipeline moves together; it holds while the output word waits.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------- stage 1
  // Edge vectors u = B-A, v = C-A, w = C-B and their component magnitudes.
  logic signed [CW-1:0]  a_c [3];
  logic signed [CW-1:0]  b_c [3];
  logic signed [CW-1:0]  c_c [3];
  logic signed [DFW-1:0] u_d [3];
  logic signed [DFW-1:0] v_d [3];
  logic signed [DFW-1:0] w_d [3];
  logic signed [DFW-1:0] u_q [3];
  logic signed [DFW-1:0] v_q [3];
  logic [MW-1:0]         mu_q [3];
  logic [MW-1:0]         mv_q [3];
  logic [MW-1:0]         mw_q [3];
  logic                  vld1_q;

  assign a_c[0] = ax_i;
  assign a_c[1] = ay_i;
  assign a_c[2] = az_i;
  assign b_c[0] = bx_i;
  assign b_c[1] = by_coord_i;
  assign b_c[2] = bz_i;
  assign c_c[0] = cx_i;
  assign c_c[1] = cy_i;
  assign c_c[2] = cz_i;

  for (genvar k = 0; k < 3; k++) begin : g_s1
    logic signed [DFW-1:0] nu;
    logic signed [DFW-1:0] nv;
    logic signed [DFW-1:0] nw;

    assign u_d[k] = {b_c[k][CW-1], b_c[k]} - {a_c[k][CW-1], a_c[k]};
    assign v_d[k] = {c_c[k][CW-1], c_c[k]} - {a_c[k][CW-1], a_c[k]};
    assign w_d[k] = {c_c[k][CW-1], c_c[k]} - {b_c[k][CW-1], b_c[k]};
    assign nu     = -u_d[k];
    assign nv     = -v_d[k];
    assign nw     = -w_d[k];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        u_q[k]  <= u_d[k];
        v_q[k]  <= v_d[k];
        mu_q[k] <= u_d[k][DFW-1] ? nu[MW-1:0] : u_d[k][MW-1:0];
        mv_q[k] <= v_d[k][DFW-1] ? nv[MW-1:0] : v_d[k][MW-1:0];
        mw_q[k] <= w_d[k][DFW-1] ? nw[MW-1:0] : w_d[k][MW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Cross product terms and squared edge components.
  logic signed [XW-1:0] xp_d [6];
  logic signed [XW-1:0] xp_q [6];
  logic [2*MW-1:0]      sq_q [9];
  logic                 vld2_q;

  assign xp_d[0] = u_q[1] * v_q[2];
  assign xp_d[1] = u_q[2] * v_q[1];
  assign xp_d[2] = u_q[2] * v_q[0];
  assign xp_d[3] = u_q[0] * v_q[2];
  assign xp_d[4] = u_q[0] * v_q[1];
  assign xp_d[5] = u_q[1] * v_q[0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        xp_q[k] <= xp_d[k];
      end
      for (int k = 0; k < 3; k++) begin
        sq_q[k]     <= mu_q[k] * mu_q[k];
        sq_q[3 + k] <= mw_q[k] * mw_q[k];
        sq_q[6 + k] <= mv_q[k] * mv_q[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Cross product magnitudes and squared edge lengths (AB, BC, CA).
  logic [NW-1:0] n_q [3];
  logic [EW-1:0] e3_q [3];
  logic          vld3_q;

  for (genvar j = 0; j < 3; j++) begin : g_s3
    logic signed [XW:0] dif;
    logic signed [XW:0] ndif;

    assign dif  = {xp_q[2*j][XW-1], xp_q[2*j]} - {xp_q[2*j+1][XW-1], xp_q[2*j+1]};
    assign ndif = -dif;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        n_q[j]  <= dif[XW] ? ndif[NW-1:0] : dif[NW-1:0];
        e3_q[j] <= EW'(sq_q[3*j]) + EW'(sq_q[3*j+1]) + EW'(sq_q[3*j+2]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Partial products of the squared cross components; zero cross means degenerate.
  logic [2*(NW-32)-1:0] hh_q [3];
  logic [NW-1:0]        hl_q [3];
  logic [63:0]          ll_q [3];
  logic [EW-1:0]        e4_q [3];
  logic                 deg4_q;
  logic                 vld4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        hh_q[j] <= n_q[j][NW-1:32] * n_q[j][NW-1:32];
        hl_q[j] <= n_q[j][NW-1:32] * n_q[j][31:0];
        ll_q[j] <= n_q[j][31:0] * n_q[j][31:0];
        e4_q[j] <= e3_q[j];
      end
      deg4_q <= (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Sum to the squared cross product length Q (= 4 * area^2 in coord units).
  logic [QW-1:0] nsq [3];
  logic [QW-1:0] q5_q;
  logic [EW-1:0] e5_q [3];
  logic          deg5_q;
  logic          vld5_q;

  for (genvar j = 0; j < 3; j++) begin : g_s5
    assign nsq[j] = (QW'(hh_q[j]) << 64) + (QW'(hl_q[j]) << 33) + QW'(ll_q[j]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q5_q   <= nsq[0] + nsq[1] + nsq[2];
      e5_q   <= e4_q;
      deg5_q <= deg4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  // ---------------------------------------------------------- edge lengths
  // Three lanes, lengths carry LEN_EXTRA extra fraction bits.
  logic [2:0][tcir_pkg::EDGE_IN_W-1:0] edge_in;
  logic [2:0][LW-1:0]                  len;
  logic                                len_vld;
  logic [QW:0]                         len_side;

  for (genvar j = 0; j < 3; j++) begin : g_edge_in
    assign edge_in[j] = {e5_q[j], {(2*XTRA){1'b0}}};
  end

  tcir_sqrt #(
    .IW    (tcir_pkg::EDGE_IN_W),
    .LANES (3),
    .SW    (QW + 1)
  ) u_edge_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld5_q),
    .x_i     (edge_in),
    .side_i  ({deg5_q, q5_q}),
    .valid_o (len_vld),
    .root_o  (len),
    .side_o  (len_side)
  );

  // ------------------------------------------------------- cross length rq
  logic [0:0][tcir_pkg::RQ_IN_W-1:0] rq_in;
  logic [0:0][RW-1:0]                rq;
  logic                              rq_vld;
  logic [3*LW:0]                     rq_side;

  assign rq_in[0] = {2'b00, len_side[QW-1:0], {(2*XTRA){1'b0}}};

  tcir_sqrt #(
    .IW    (tcir_pkg::RQ_IN_W),
    .LANES (1),
    .SW    (3 * LW + 1)
  ) u_rq_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (len_vld),
    .x_i     (rq_in),
    .side_i  ({len_side[QW], len[0], len[1], len[2]}),
    .valid_o (rq_vld),
    .root_o  (rq),
    .side_o  (rq_side)
  );

  // ------------------------------------------------------------ product m1
  // la*lb in four partial products; perimeter sum on the side.
  logic [LW-1:0]  la;
  logic [LW-1:0]  lb;
  logic [LW-1:0]  lc;
  logic [63:0]    ab_ll_q;
  logic [LW-1:0]  ab_lh_q;
  logic [LW-1:0]  ab_hl_q;
  logic [2*(LW-32)-1:0] ab_hh_q;
  logic [LW-1:0]  lc1_q;
  logic [RW-1:0]  rq1_q;
  logic [SMW-1:0] s1_q;
  logic           deg1_q;
  logic           vm1_q;

  assign la = rq_side[3*LW-1:2*LW];
  assign lb = rq_side[2*LW-1:LW];
  assign lc = rq_side[LW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ab_ll_q <= la[31:0] * lb[31:0];
      ab_lh_q <= la[31:0] * lb[LW-1:32];
      ab_hl_q <= la[LW-1:32] * lb[31:0];
      ab_hh_q <= la[LW-1:32] * lb[LW-1:32];
      lc1_q   <= lc;
      rq1_q   <= rq[0];
      s1_q    <= SMW'(la) + SMW'(lb) + SMW'(lc);
      deg1_q  <= rq_side[3*LW];
    end
  end

  // ------------------------------------------------------------ product m2
  logic [ABW-1:0] ab2_q;
  logic [LW-1:0]  lc2_q;
  logic [RW-1:0]  rq2_q;
  logic [SMW-1:0] s2_q;
  logic           deg2_q;
  logic           vm2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ab2_q  <= (ABW'(ab_hh_q) << 64) + (ABW'(ab_lh_q) << 32)
              + (ABW'(ab_hl_q) << 32) + ABW'(ab_ll_q);
      lc2_q  <= lc1_q;
      rq2_q  <= rq1_q;
      s2_q   <= s1_q;
      deg2_q <= deg1_q;
    end
  end

  // ------------------------------------------------------------ product m3
  // (la*lb)*lc in six partial products.
  logic [63:0]           p00_q;
  logic [LW-1:0]         p01_q;
  logic [63:0]           p10_q;
  logic [LW-1:0]         p11_q;
  logic [ABW-64+31:0]    p20_q;
  logic [ABW-64+LW-33:0] p21_q;
  logic [RW-1:0]         rq3_q;
  logic [SMW-1:0]        s3_q;
  logic                  deg3_q;
  logic                  vm3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p00_q  <= ab2_q[31:0] * lc2_q[31:0];
      p01_q  <= ab2_q[31:0] * lc2_q[LW-1:32];
      p10_q  <= ab2_q[63:32] * lc2_q[31:0];
      p11_q  <= ab2_q[63:32] * lc2_q[LW-1:32];
      p20_q  <= ab2_q[ABW-1:64] * lc2_q[31:0];
      p21_q  <= ab2_q[ABW-1:64] * lc2_q[LW-1:32];
      rq3_q  <= rq2_q;
      s3_q   <= s2_q;
      deg3_q <= deg2_q;
    end
  end

  // ------------------------------------------------------------ product m4
  logic [PW-1:0]  p4_q;
  logic [RW-1:0]  rq4_q;
  logic [SMW-1:0] s4_q;
  logic           deg4m_q;
  logic           vm4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_q    <= PW'(p00_q) + (PW'(p01_q) << 32) + (PW'(p10_q) << 32)
               + (PW'(p11_q) << 64) + (PW'(p20_q) << 64) + (PW'(p21_q) << 96);
      rq4_q   <= rq3_q;
      s4_q    <= s3_q;
      deg4m_q <= deg3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      vm3_q <= 1'b0;
      vm4_q <= 1'b0;
    end else if (adv) begin
      vm1_q <= rq_vld;
      vm2_q <= vm1_q;
      vm3_q <= vm2_q;
      vm4_q <= vm3_q;
    end
  end

  // -------------------------------------------------------------- division
  // Lane 0: circumradius, lane 1: inradius.
  logic [1:0][DNW-1:0] div_num;
  logic [1:0][DDW-1:0] div_den;
  logic [1:0][OW-1:0]  quot;
  logic                div_vld;
  logic                div_deg;

  assign div_num[0] = DNW'(p4_q >> CN_SHIFT);
  assign div_den[0] = DDW'(rq4_q);
  assign div_num[1] = DNW'(rq4_q) << OFRAC;
  assign div_den[1] = DDW'(s4_q) << COORD_FRAC_BITS;

  tcir_div #(
    .NW    (DNW),
    .DW    (DDW),
    .QW    (OW),
    .LANES (2),
    .SW    (1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vm4_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .side_i  (deg4m_q),
    .valid_o (div_vld),
    .quot_o  (quot),
    .side_o  (div_deg)
  );

  // ------------------------------------------------------------ output word
  // Degenerate triangles force the circumradius to full scale and zero the inradius.
  logic [OW-1:0] circ_q;
  logic [OW-1:0] inr_q;
  logic          deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      circ_q <= div_deg ? tcir_pkg::OUT_MAX : quot[0];
      inr_q  <= div_deg ? '0 : quot[1];
      deg_q  <= div_deg;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign circum_radius_o = circ_q;
  assign in_radius_o     = inr_q;
  assign degenerate_o    = deg_q;

  // -------------------------------------------------------------- checks
  `TCIR_ASSERT_NOW(a_deg_out, clk_i, rst_ni, out_valid_o && degenerate_o, (circum_radius_o == tcir_pkg::OUT_MAX) && (in_radius_o == '0))
  `TCIR_ASSERT_NOW(a_ready_free, clk_i, rst_ni, !in_ready_o, out_valid_o)
  `TCIR_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(div_vld) && $stable(vm4_q) && $stable(rq_vld))

endmodule

[sim/triangle_circum_and_in_radius_unit_tb.sv]
// Self-checking bench for triangle_circum_and_in_radius_unit: circumradius, inradius and
// degenerate flag for streams of 3-D triangles. Depends on tcir_pkg and the unit itself.
`timescale 1ns / 1ps

module triangle_circum_and_in_radius_unit_tb;

  localparam int LATENCY     = 191;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_RANDOM    = 430;

  typedef struct {
    logic signed [tcir_pkg::COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    bit                                  drain_first; // hold until every result is back
  } tri_t;

  typedef struct {
    logic [tcir_pkg::OUT_W-1:0] circ;
    logic [tcir_pkg::OUT_W-1:0] inr;
    logic                       degen;
  } radii_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [tcir_pkg::COORD_W-1:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [tcir_pkg::COORD_W-1:0] bx_i = '0, by_coord_i = '0, bz_i = '0;
  logic signed [tcir_pkg::COORD_W-1:0] cx_i = '0, cy_i = '0, cz_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [tcir_pkg::OUT_W-1:0] circum_radius_o, in_radius_o;
  logic degenerate_o;

  tri_t   tri_q[$];
  radii_t radii_q[$];
  int     n_sent = 0, n_got = 0, n_bad = 0, n_degen = 0, n_sat = 0;
  int     hold_left = 0;
  bit     quiet = 1'b0;
  bit     hold_done = 1'b0;

  always #10 clk_i = ~clk_i;

  triangle_circum_and_in_radius_unit dut (.*);

  // floor(sqrt(v)), one bit at a time from the top
  function automatic logic [255:0] isqrt(input logic [255:0] v);
    logic [255:0] r, t;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      t = r | (256'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [255:0] mag(input longint d);
    return (d < 0) ? 256'(-d) : 256'(d);
  endfunction

  // length of one edge in units of 2^-(F+16)
  function automatic logic [255:0] edge_len(input longint dx, input longint dy,
                                            input longint dz);
    logic [255:0] s;
    s = mag(dx) * mag(dx) + mag(dy) * mag(dy) + mag(dz) * mag(dz);
    return isqrt(s << (2 * tcir_pkg::LEN_EXTRA));
  endfunction

  function automatic logic [tcir_pkg::OUT_W-1:0] sat_div(input logic [255:0] n,
                                                         input logic [255:0] d);
    logic [255:0] q;
    if (d == 0) return tcir_pkg::OUT_MAX;
    q = n / d;
    return (q >= (256'd1 << tcir_pkg::OUT_W)) ? tcir_pkg::OUT_MAX : q[tcir_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [255:0] sq_abs(input logic signed [127:0] v);
    logic [255:0] m;
    m = (v < 0) ? 256'(-v) : 256'(v);
    return m * m;
  endfunction

  // expected radii of one triangle
  function automatic radii_t triangle_radii(input tri_t t);
    radii_t r;
    longint ux, uy, uz, vx, vy, vz;
    logic signed [127:0] nx, ny, nz;
    logic [255:0] area2, rq, la, lb, lc;
    ux = longint'(t.bx) - longint'(t.ax);
    uy = longint'(t.by) - longint'(t.ay);
    uz = longint'(t.bz) - longint'(t.az);
    vx = longint'(t.cx) - longint'(t.ax);
    vy = longint'(t.cy) - longint'(t.ay);
    vz = longint'(t.cz) - longint'(t.az);
    nx = 128'(uy) * 128'(vz) - 128'(uz) * 128'(vy);
    ny = 128'(uz) * 128'(vx) - 128'(ux) * 128'(vz);
    nz = 128'(ux) * 128'(vy) - 128'(uy) * 128'(vx);
    area2 = sq_abs(nx) + sq_abs(ny) + sq_abs(nz);
    if (area2 == 0) begin
      r.circ = tcir_pkg::OUT_MAX; r.inr = '0; r.degen = 1'b1;
      return r;
    end
    rq = isqrt(area2 << (2 * tcir_pkg::LEN_EXTRA));
    la = edge_len(ux, uy, uz);
    lb = edge_len(longint'(t.cx) - longint'(t.bx), longint'(t.cy) - longint'(t.by),
                  longint'(t.cz) - longint'(t.bz));
    lc = edge_len(-vx, -vy, -vz);
    r.circ  = sat_div((la * lb * lc) << tcir_pkg::OUT_FRAC,
                      rq << (1 + tcir_pkg::COORD_FRAC_DEF + 2 * tcir_pkg::LEN_EXTRA));
    r.inr   = sat_div(rq << tcir_pkg::OUT_FRAC, (la + lb + lc) << tcir_pkg::COORD_FRAC_DEF);
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic tri_t mk(input logic signed [31:0] ax, ay, az, bx, by, bz,
                              cx, cy, cz);
    tri_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz, 1'b0};
    return t;
  endfunction

  function automatic logic signed [31:0] pick(input int span);
    return (span >= 32) ? $urandom : ($signed($urandom_range((1 << span) - 1)) -
                                      (1 << (span - 1)));
  endfunction

  // Sender: hold the word until taken, then advance; idle at random outside the
  // quiet stretch; honor the drain request of the head word.
  always @(posedge clk_i or negedge rst_ni) begin
    tri_t t;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        radii_q.push_back(triangle_radii(mk(ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i,
                                            cx_i, cy_i, cz_i)));
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tri_q.size() != 0 && !(tri_q[0].drain_first && radii_q.size() != 0) &&
            (quiet || $urandom_range(99) >= 18)) begin
          t = tri_q.pop_front();
          ax_i <= t.ax; ay_i <= t.ay; az_i <= t.az;
          bx_i <= t.bx; by_coord_i <= t.by; bz_i <= t.bz;
          cx_i <= t.cx; cy_i <= t.cy; cz_i <= t.cz;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string what, input logic [tcir_pkg::OUT_W-1:0] got, exp_v);
    n_bad++;
    $display("word %0d: %s got %h expected %h", n_got, what, got, exp_v);
  endtask

  // Receiver: check each word against the oldest expectation; once, drop ready
  // for a long stretch so the pipeline fills and backs up into the input.
  always @(posedge clk_i or negedge rst_ni) begin
    radii_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (radii_q.size() == 0) begin
          report("unexpected word", circum_radius_o, '0);
        end else begin
          e = radii_q.pop_front();
          if (circum_radius_o !== e.circ) report("circum_radius", circum_radius_o, e.circ);
          if (in_radius_o !== e.inr) report("in_radius", in_radius_o, e.inr);
          if (degenerate_o !== e.degen) report("degenerate", degenerate_o, e.degen);
          if (e.degen) n_degen++;
          else if (e.circ == tcir_pkg::OUT_MAX) n_sat++;
        end
        n_got++;
      end
      quiet <= (n_got >= 150 && n_got < 300);
      if (!hold_done && n_got == 60) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= (hold_left == 1);
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 18);
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    int idle_cycles;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else if (rst_ni && (tri_q.size() != 0 || radii_q.size() != 0)) idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("triangle_circum_and_in_radius_unit: mismatch");
      $finish;
    end
  end

  initial begin
    tri_t t;
    int   k;
    // directed: degenerate shapes, extremes, plain and saturating triangles
    tri_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_q.push_back(mk(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    tri_q.push_back(mk(0, 0, 0, 32'h10000, 0, 0, 32'h20000, 0, 0));
    tri_q.push_back(mk(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    tri_q.push_back(mk(0, 0, 0, 32'h30000, 0, 0, 0, 32'h40000, 0));
    tri_q.push_back(mk(0, 0, 0, 32'h20000, 0, 0, 32'h10000, 32'h1bb68, 0));
    tri_q.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    tri_q.push_back(mk(0, 0, 0, 0, 0, 1, 0, 1, 0));
    tri_q.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh80000000,
                       32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                       32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    tri_q.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                       32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                       32'sh7fffffff, 32'sh80000000, 32'sh80000000));
    tri_q.push_back(mk(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 0, 1, 0));
    tri_q.push_back(mk(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 1));
    tri_q.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh80000000,
                       32'sh80000000, 32'sh80000000, 32'sh80000000,
                       32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    tri_q.push_back(mk(32'sh80000000, 32'sh80000000, 0, 0, 0, 0,
                       32'sh7fffffff, 32'sh7fffffff, 0));
    tri_q.push_back(mk(-1, -1, -1, 1, 1, 1, -1, 1, -1));
    tri_q.push_back(mk(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                       32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                       32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    // random: small and mid-size triangles as the largest share, some full-range, some
    // collinear or coincident, and some nearly flat
    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(99);
      if (k < 30) t = mk(pick(20), pick(20), pick(20), pick(20), pick(20), pick(20),
                         pick(20), pick(20), pick(20));
      else if (k < 55) t = mk(pick(32), pick(32), pick(32), pick(32), pick(32),
                              pick(32), pick(32), pick(32), pick(32));
      else if (k < 70) t = mk(pick(8), pick(8), pick(8), pick(8), pick(8), pick(8),
                              pick(8), pick(8), pick(8));
      else if (k < 82) begin
        t = mk(pick(28), pick(28), pick(28), pick(12), pick(12), pick(12), 0, 0, 0);
        k = $signed($urandom_range(6)) - 3;
        t.cx = t.ax + k * t.bx; t.cy = t.ay + k * t.by; t.cz = t.az + k * t.bz;
        t.bx = t.ax + t.bx; t.by = t.ay + t.by; t.bz = t.az + t.bz;
      end else if (k < 88) begin
        t = mk(pick(32), pick(32), pick(32), 0, 0, 0, 0, 0, 0);
        t.bx = t.ax; t.by = t.ay; t.bz = t.az;
        t.cx = ($urandom_range(1)) ? t.ax : pick(32);
        t.cy = t.ay; t.cz = ($urandom_range(1)) ? t.az : pick(32);
      end else begin
        t = mk(pick(32), pick(32), pick(32), 0, 0, 0, 0, 0, 0);
        t.bx = t.ax + pick(31); t.by = t.ay; t.bz = t.az;
        t.cx = t.ax + pick(30); t.cy = t.ay + pick(2); t.cz = t.az + pick(2);
      end
      t.drain_first = (i == 250);
      tri_q.push_back(t);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (tri_q.size() == 0 && !in_valid_i && radii_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("covered %0d triangles: %0d degenerate, %0d with circumradius saturated",
             n_sent, n_degen, n_sat);
    $display("back-pressure hold of %0d cycles and a full drain mid-run", HOLD_CYCLES);
    if (n_bad == 0 && radii_q.size() == 0) begin
      $display("triangle_circum_and_in_radius_unit: match");
    end else begin
      $display("triangle_circum_and_in_radius_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tcir_pkg.sv
rtl/tcir_sqrt.sv
rtl/tcir_div.sv
rtl/triangle_circum_and_in_radius_unit.sv
sim/triangle_circum_and_in_radius_unit_tb.sv
